// ===== sv/mi3_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse pipeline.
package mi3_pkg;

  // Elements in one 3x3 matrix.
  localparam int unsigned NUM_ELEM = 9;

  // Status flags that travel with every result.
  typedef struct packed {
    logic singular;
    logic clipped;
  } mi3_flags_t;

endpackage

// ===== sv/mi3_front.sv =====
// Front pipeline: minor products, cofactors, determinant expansion and magnitudes.
module mi3_front
  import mi3_pkg::*;
#(
  parameter int IN_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ce,
  input  logic                       in_valid,
  input  logic signed [IN_WIDTH-1:0] in_a [NUM_ELEM],
  output logic                       out_valid,
  output logic [2*IN_WIDTH:0]        out_mag [NUM_ELEM],
  output logic                       out_neg [NUM_ELEM],
  output logic [3*IN_WIDTH+2:0]      out_dmag,
  output logic                       out_zero
);

  localparam int CW   = 2 * IN_WIDTH + 1;
  localparam int PW   = 2 * IN_WIDTH;
  localparam int DPW  = IN_WIDTH + CW;
  localparam int DETW = 3 * IN_WIDTH + 3;

  logic                       v1_r, v2_r, v3_r, v4_r;
  logic signed [PW-1:0]       p1_r [18];
  logic signed [IN_WIDTH-1:0] a1_r [3];
  logic signed [IN_WIDTH-1:0] a2_r [3];
  logic signed [CW-1:0]       c2_r [NUM_ELEM];
  logic signed [DPW-1:0]      dp3_r [3];
  logic [CW-1:0]              mag3_r [NUM_ELEM];
  logic                       neg3_r [NUM_ELEM];
  logic [CW-1:0]              mag4_r [NUM_ELEM];
  logic                       neg4_r [NUM_ELEM];
  logic [DETW-1:0]            dmag4_r;
  logic                       zero4_r;
  logic [DETW-1:0]            det_sum;
  logic                       det_neg;

  // Valid bits follow the data through the four stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage 1: the eighteen 2x2-minor products
  always_ff @(posedge clk) begin
    if (ce) begin
      p1_r[0]  <= in_a[4] * in_a[8];
      p1_r[1]  <= in_a[5] * in_a[7];
      p1_r[2]  <= in_a[5] * in_a[6];
      p1_r[3]  <= in_a[3] * in_a[8];
      p1_r[4]  <= in_a[3] * in_a[7];
      p1_r[5]  <= in_a[4] * in_a[6];
      p1_r[6]  <= in_a[2] * in_a[7];
      p1_r[7]  <= in_a[1] * in_a[8];
      p1_r[8]  <= in_a[0] * in_a[8];
      p1_r[9]  <= in_a[2] * in_a[6];
      p1_r[10] <= in_a[1] * in_a[6];
      p1_r[11] <= in_a[0] * in_a[7];
      p1_r[12] <= in_a[1] * in_a[5];
      p1_r[13] <= in_a[2] * in_a[4];
      p1_r[14] <= in_a[2] * in_a[3];
      p1_r[15] <= in_a[0] * in_a[5];
      p1_r[16] <= in_a[0] * in_a[4];
      p1_r[17] <= in_a[1] * in_a[3];
      for (int k = 0; k < 3; k++) begin
        a1_r[k] <= in_a[k];
      end
    end
  end

  // Stage 2: signed cofactors, exact in CW bits
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        c2_r[k] <= {p1_r[2*k][PW-1], p1_r[2*k]} - {p1_r[2*k+1][PW-1], p1_r[2*k+1]};
      end
      for (int k = 0; k < 3; k++) begin
        a2_r[k] <= a1_r[k];
      end
    end
  end

  // Stage 3: first-row determinant terms; adjugate is the cofactor transpose
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        dp3_r[k] <= a2_r[k] * c2_r[k];
      end
      for (int k = 0; k < NUM_ELEM; k++) begin
        neg3_r[k] <= c2_r[(k % 3) * 3 + k / 3][CW-1];
        mag3_r[k] <= c2_r[(k % 3) * 3 + k / 3][CW-1] ?
                     (CW'(0) - c2_r[(k % 3) * 3 + k / 3]) : c2_r[(k % 3) * 3 + k / 3];
      end
    end
  end

  // Stage 4: determinant sum, zero test and magnitude
  assign det_sum = {{(DETW-DPW){dp3_r[0][DPW-1]}}, dp3_r[0]}
                 + {{(DETW-DPW){dp3_r[1][DPW-1]}}, dp3_r[1]}
                 + {{(DETW-DPW){dp3_r[2][DPW-1]}}, dp3_r[2]};
  assign det_neg = det_sum[DETW-1];

  always_ff @(posedge clk) begin
    if (ce) begin
      dmag4_r <= det_neg ? (DETW'(0) - det_sum) : det_sum;
      zero4_r <= (det_sum == '0);
      for (int k = 0; k < NUM_ELEM; k++) begin
        mag4_r[k] <= mag3_r[k];
        neg4_r[k] <= neg3_r[k] ^ det_neg;
      end
    end
  end

  assign out_valid = v4_r;
  assign out_mag   = mag4_r;
  assign out_neg   = neg4_r;
  assign out_dmag  = dmag4_r;
  assign out_zero  = zero4_r;

endmodule

// ===== sv/mi3_divider.sv =====
// Nine-lane pipelined restoring divider with saturation to the output format.
module mi3_divider
  import mi3_pkg::*;
#(
  parameter int IN_WIDTH  = 16,
  parameter int OUT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ce,
  input  logic                 in_valid,
  input  logic [2*IN_WIDTH:0]  in_mag [NUM_ELEM],
  input  logic                 in_neg [NUM_ELEM],
  input  logic [3*IN_WIDTH+2:0] in_dmag,
  input  logic                 in_zero,
  output logic                 out_valid,
  output logic [OUT_WIDTH-1:0] out_val [NUM_ELEM],
  output mi3_flags_t           out_flags
);

  localparam int CW   = 2 * IN_WIDTH + 1;
  localparam int DETW = 3 * IN_WIDTH + 3;
  localparam int SH   = IN_WIDTH / 2 + OUT_WIDTH / 2;
  localparam int QW   = OUT_WIDTH + 1;
  localparam int NW   = CW + SH;
  localparam int EW   = (NW > DETW + QW) ? NW : DETW + QW;

  logic          v_r    [QW+1];
  logic [EW-1:0] rem_r  [QW+1][NUM_ELEM];
  logic [QW-1:0] q_r    [QW+1][NUM_ELEM];
  logic          neg_r  [QW+1][NUM_ELEM];
  logic          mz_r   [QW+1][NUM_ELEM];
  logic          ovf_r  [QW+1][NUM_ELEM];
  logic [EW-1:0] dm_r   [QW+1];
  logic          zero_r [QW+1];

  logic [EW-1:0]        num_in [NUM_ELEM];
  logic [EW-1:0]        dm_in;
  logic                 vo_r;
  logic [OUT_WIDTH-1:0] val_r [NUM_ELEM];
  logic                 sing_r;
  logic                 clip_r;
  logic [OUT_WIDTH-1:0] val_nxt [NUM_ELEM];
  logic [NUM_ELEM-1:0]  clip_nxt;

  localparam logic [QW-1:0] MAXMAG = {2'b00, {(OUT_WIDTH-1){1'b1}}};
  localparam logic [QW-1:0] MINMAG = QW'(1) << (OUT_WIDTH - 1);

  // Entry stage: scaled numerators and the quotient overflow test
  assign dm_in = {{(EW-DETW){1'b0}}, in_dmag};
  always_comb begin
    for (int l = 0; l < NUM_ELEM; l++) begin
      num_in[l] = {{(EW-CW){1'b0}}, in_mag[l]} << SH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dm_r[0]   <= dm_in;
      zero_r[0] <= in_zero;
      for (int l = 0; l < NUM_ELEM; l++) begin
        rem_r[0][l] <= num_in[l];
        q_r[0][l]   <= '0;
        neg_r[0][l] <= in_neg[l];
        mz_r[0][l]  <= (in_mag[l] == '0);
        ovf_r[0][l] <= (num_in[l] >= (dm_in << QW));
      end
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 1; j <= QW; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (ce) begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        dm_r[j]   <= dm_r[j-1];
        zero_r[j] <= zero_r[j-1];
        for (int l = 0; l < NUM_ELEM; l++) begin
          neg_r[j][l] <= neg_r[j-1][l];
          mz_r[j][l]  <= mz_r[j-1][l];
          ovf_r[j][l] <= ovf_r[j-1][l];
          if (rem_r[j-1][l] >= (dm_r[j-1] << (QW - j))) begin
            rem_r[j][l] <= rem_r[j-1][l] - (dm_r[j-1] << (QW - j));
            q_r[j][l]   <= {q_r[j-1][l][QW-2:0], 1'b1};
          end else begin
            rem_r[j][l] <= rem_r[j-1][l];
            q_r[j][l]   <= {q_r[j-1][l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Saturate, apply sign, force zeros for a singular matrix
  always_comb begin
    for (int l = 0; l < NUM_ELEM; l++) begin
      val_nxt[l]  = '0;
      clip_nxt[l] = 1'b0;
      if (!zero_r[QW] && !mz_r[QW][l]) begin
        if (neg_r[QW][l]) begin
          if (ovf_r[QW][l] || q_r[QW][l] > MINMAG) begin
            val_nxt[l]  = MINMAG[OUT_WIDTH-1:0];
            clip_nxt[l] = 1'b1;
          end else begin
            val_nxt[l] = OUT_WIDTH'(0) - q_r[QW][l][OUT_WIDTH-1:0];
          end
        end else begin
          if (ovf_r[QW][l] || q_r[QW][l] > MAXMAG) begin
            val_nxt[l]  = MAXMAG[OUT_WIDTH-1:0];
            clip_nxt[l] = 1'b1;
          end else begin
            val_nxt[l] = q_r[QW][l][OUT_WIDTH-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (ce) begin
      vo_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      val_r  <= val_nxt;
      sing_r <= zero_r[QW];
      clip_r <= |clip_nxt;
    end
  end

  assign out_valid          = vo_r;
  assign out_val            = val_r;
  assign out_flags.singular = sing_r;
  assign out_flags.clipped  = clip_r;

endmodule

// ===== sv/mi3_skid.sv =====
// Two-entry output skid buffer; ready toward the pipeline is registered.
module mi3_skid #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             main_v_r;
  logic             skid_v_r;
  logic [WIDTH-1:0] main_d_r;
  logic [WIDTH-1:0] skid_d_r;

  assign in_ready = !skid_v_r;

  // Control: main register feeds the port, skid catches a transfer during a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (in_valid) begin
      if (main_v_r && !out_ready) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end else if (out_ready) begin
      main_v_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        main_d_r <= skid_d_r;
      end
    end else if (in_valid) begin
      if (main_v_r && !out_ready) begin
        skid_d_r <= in_data;
      end else begin
        main_d_r <= in_data;
      end
    end
  end

  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

endmodule

// ===== sv/matrix_inverse_3x3.sv =====
// Top level of the pipelined 3x3 matrix inverse (adjugate over determinant).
//
// Input channel: in_valid/in_ready with nine signed Q8.8 elements in_a00..in_a22.
// Result channel: out_valid/out_ready with nine signed Q16.16 elements
// out_b00..out_b22, plus out_singular (determinant is zero, elements are zero)
// and out_clipped (some element saturated to the Q16.16 range).
// Throughput: one matrix per cycle while in_ready is high. A transfer on the
// input passes through four stages of products, cofactors and determinant, an
// overflow-test stage, one stage per quotient bit (OUT_WIDTH + 1) in the
// nine-lane divider, a saturation stage and the output register.
// The whole pipeline advances together; a two-entry output buffer takes the
// last item when the receiver stalls, and in_ready then drops until it drains.
// Nothing is lost or repeated across a stall. Reset (rst_n low, synchronous)
// empties the pipeline and the output buffer; no item is in flight after it.
module matrix_inverse_3x3
  import mi3_pkg::*;
#(
  parameter int IN_WIDTH  = 16,
  parameter int OUT_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [IN_WIDTH-1:0]  in_a00,
  input  logic signed [IN_WIDTH-1:0]  in_a01,
  input  logic signed [IN_WIDTH-1:0]  in_a02,
  input  logic signed [IN_WIDTH-1:0]  in_a10,
  input  logic signed [IN_WIDTH-1:0]  in_a11,
  input  logic signed [IN_WIDTH-1:0]  in_a12,
  input  logic signed [IN_WIDTH-1:0]  in_a20,
  input  logic signed [IN_WIDTH-1:0]  in_a21,
  input  logic signed [IN_WIDTH-1:0]  in_a22,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_WIDTH-1:0] out_b00,
  output logic signed [OUT_WIDTH-1:0] out_b01,
  output logic signed [OUT_WIDTH-1:0] out_b02,
  output logic signed [OUT_WIDTH-1:0] out_b10,
  output logic signed [OUT_WIDTH-1:0] out_b11,
  output logic signed [OUT_WIDTH-1:0] out_b12,
  output logic signed [OUT_WIDTH-1:0] out_b20,
  output logic signed [OUT_WIDTH-1:0] out_b21,
  output logic signed [OUT_WIDTH-1:0] out_b22,
  output logic                        out_singular,
  output logic                        out_clipped
);

  localparam int CW   = 2 * IN_WIDTH + 1;
  localparam int DETW = 3 * IN_WIDTH + 3;
  localparam int RW   = NUM_ELEM * OUT_WIDTH + 2;

  logic                       ce;
  logic signed [IN_WIDTH-1:0] a_in [NUM_ELEM];
  logic                       fr_valid;
  logic [CW-1:0]              fr_mag [NUM_ELEM];
  logic                       fr_neg [NUM_ELEM];
  logic [DETW-1:0]            fr_dmag;
  logic                       fr_zero;
  logic                       dv_valid;
  logic [OUT_WIDTH-1:0]       dv_val [NUM_ELEM];
  mi3_flags_t                 dv_flags;
  logic [RW-1:0]              res_in;
  logic [RW-1:0]              res_out;

  assign a_in[0] = in_a00;
  assign a_in[1] = in_a01;
  assign a_in[2] = in_a02;
  assign a_in[3] = in_a10;
  assign a_in[4] = in_a11;
  assign a_in[5] = in_a12;
  assign a_in[6] = in_a20;
  assign a_in[7] = in_a21;
  assign a_in[8] = in_a22;

  // Whole pipeline steps whenever the output buffer has room
  assign in_ready = ce;

  mi3_front #(
    .IN_WIDTH(IN_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (in_valid),
    .in_a     (a_in),
    .out_valid(fr_valid),
    .out_mag  (fr_mag),
    .out_neg  (fr_neg),
    .out_dmag (fr_dmag),
    .out_zero (fr_zero)
  );

  mi3_divider #(
    .IN_WIDTH (IN_WIDTH),
    .OUT_WIDTH(OUT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (fr_valid),
    .in_mag   (fr_mag),
    .in_neg   (fr_neg),
    .in_dmag  (fr_dmag),
    .in_zero  (fr_zero),
    .out_valid(dv_valid),
    .out_val  (dv_val),
    .out_flags(dv_flags)
  );

  // Pack the result for the output buffer
  assign res_in = {dv_val[0], dv_val[1], dv_val[2], dv_val[3], dv_val[4],
                   dv_val[5], dv_val[6], dv_val[7], dv_val[8],
                   dv_flags.singular, dv_flags.clipped};

  mi3_skid #(
    .WIDTH(RW)
  ) u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dv_valid),
    .in_ready (ce),
    .in_data  (res_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (res_out)
  );

  assign out_b00      = res_out[2+8*OUT_WIDTH +: OUT_WIDTH];
  assign out_b01      = res_out[2+7*OUT_WIDTH +: OUT_WIDTH];
  assign out_b02      = res_out[2+6*OUT_WIDTH +: OUT_WIDTH];
  assign out_b10      = res_out[2+5*OUT_WIDTH +: OUT_WIDTH];
  assign out_b11      = res_out[2+4*OUT_WIDTH +: OUT_WIDTH];
  assign out_b12      = res_out[2+3*OUT_WIDTH +: OUT_WIDTH];
  assign out_b20      = res_out[2+2*OUT_WIDTH +: OUT_WIDTH];
  assign out_b21      = res_out[2+1*OUT_WIDTH +: OUT_WIDTH];
  assign out_b22      = res_out[2 +: OUT_WIDTH];
  assign out_singular = res_out[1];
  assign out_clipped  = res_out[0];

endmodule

// ===== sim/tb.sv =====
// Testbench for the 3x3 matrix inverse: random and directed matrices, checked against a predictor.
module tb;
  import mi3_pkg::*;

  localparam int IW = 16;
  localparam int OW = 32;
  localparam int LATENCY = OW + 7;
  localparam int N_RANDOM = 1030;

  typedef logic signed [IW-1:0] elem_t;
  typedef logic signed [OW-1:0] inv_t;

  typedef struct {
    elem_t a [9];
  } matrix_t;

  typedef struct {
    inv_t       b [9];
    mi3_flags_t flags;
  } inverse_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  elem_t in_a [9];
  inv_t out_b [9];
  logic in_ready, out_valid, out_singular, out_clipped;

  matrix_t  pending_q [$];
  inverse_t expected_q [$];
  int errors = 0;
  bit stim_done = 1'b0;
  int hold_cycles = 0;
  bit long_hold_done = 1'b0;

  initial for (int k = 0; k < 9; k++) in_a[k] = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  matrix_inverse_3x3 #(.IN_WIDTH(IW), .OUT_WIDTH(OW)) dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_a00(in_a[0]), .in_a01(in_a[1]), .in_a02(in_a[2]),
    .in_a10(in_a[3]), .in_a11(in_a[4]), .in_a12(in_a[5]),
    .in_a20(in_a[6]), .in_a21(in_a[7]), .in_a22(in_a[8]),
    .out_valid, .out_ready,
    .out_b00(out_b[0]), .out_b01(out_b[1]), .out_b02(out_b[2]),
    .out_b10(out_b[3]), .out_b11(out_b[4]), .out_b12(out_b[5]),
    .out_b20(out_b[6]), .out_b21(out_b[7]), .out_b22(out_b[8]),
    .out_singular, .out_clipped
  );

  // Exact inverse via adjugate; each element truncated toward zero, then saturated.
  function automatic inverse_t invert(matrix_t m);
    logic signed [63:0] x [9];
    logic signed [63:0] cof [9];
    logic signed [127:0] det, num, q;
    inverse_t r;
    for (int k = 0; k < 9; k++) x[k] = m.a[k];
    cof[0] = x[4]*x[8] - x[5]*x[7];
    cof[1] = x[5]*x[6] - x[3]*x[8];
    cof[2] = x[3]*x[7] - x[4]*x[6];
    cof[3] = x[2]*x[7] - x[1]*x[8];
    cof[4] = x[0]*x[8] - x[2]*x[6];
    cof[5] = x[1]*x[6] - x[0]*x[7];
    cof[6] = x[1]*x[5] - x[2]*x[4];
    cof[7] = x[2]*x[3] - x[0]*x[5];
    cof[8] = x[0]*x[4] - x[1]*x[3];
    det = 128'(x[0]) * cof[0] + 128'(x[1]) * cof[1] + 128'(x[2]) * cof[2];
    r.flags.singular = (det == 0);
    r.flags.clipped = 1'b0;
    for (int k = 0; k < 9; k++) begin
      r.b[k] = '0;
      if (det != 0) begin
        // adjugate element (row k/3, col k%3) is cofactor (k%3, k/3)
        num = 128'(cof[(k % 3) * 3 + k / 3]) <<< (IW / 2 + OW / 2);
        q = num / det;  // SV signed division truncates toward zero
        if (q > 128'sd2147483647) begin
          r.b[k] = 32'sh7fffffff;
          r.flags.clipped = 1'b1;
        end else if (q < -128'sd2147483648) begin
          r.b[k] = 32'sh80000000;
          r.flags.clipped = 1'b1;
        end else begin
          r.b[k] = q[OW-1:0];
        end
      end
    end
    return r;
  endfunction

  function automatic elem_t rand_elem(int mode);
    case (mode)
      0: return elem_t'($urandom);
      1: return elem_t'($urandom_range(0, 512) - 256);  // near unity scale
      2: return elem_t'($urandom_range(0, 16) - 8);     // tiny, big inverses
      default: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // Stimulus
  initial begin
    matrix_t m;
    int mode;
    // identity in Q8.8
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? 16'sh0100 : 16'sh0000;
    pending_q.push_back(m);
    // all zero, all max, all min: singular
    foreach (m.a[k]) m.a[k] = 16'sh0000;
    pending_q.push_back(m);
    foreach (m.a[k]) m.a[k] = 16'sh7fff;
    pending_q.push_back(m);
    foreach (m.a[k]) m.a[k] = 16'sh8000;
    pending_q.push_back(m);
    // diagonal extremes: large and small inverses of both signs
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? 16'sh0001 : 16'sh0000;
    pending_q.push_back(m);
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? 16'shffff : 16'sh0000;
    pending_q.push_back(m);
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? 16'sh8000 : 16'sh0000;
    pending_q.push_back(m);
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? 16'sh7fff : 16'sh0000;
    pending_q.push_back(m);
    // permutation (negative determinant)
    foreach (m.a[k]) m.a[k] = (k == 1 || k == 3 || k == 8) ? 16'sh0100 : 16'sh0000;
    pending_q.push_back(m);
    // alternating extremes, full cofactor range
    foreach (m.a[k]) m.a[k] = (k % 2) ? 16'sh8000 : 16'sh7fff;
    pending_q.push_back(m);
    foreach (m.a[k]) m.a[k] = (k == 0 || k == 4 || k == 8) ? 16'sh8000 : 16'sh7fff;
    pending_q.push_back(m);
    // rank-deficient with nonzero elements
    foreach (m.a[k]) m.a[k] = elem_t'((k / 3 + 1) * (k % 3 + 1) * 16);
    pending_q.push_back(m);
    // minimal diagonal with one negative entry
    foreach (m.a[k]) m.a[k] = (k % 4 == 0) ? 16'sh0001 : 16'sh0000;
    m.a[8] = 16'shffff;
    pending_q.push_back(m);
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 4) ? 0 : (mode < 8) ? 1 : (mode < 9) ? 2 : 3;
      foreach (m.a[k]) m.a[k] = ($urandom_range(0, 15) == 0) ? rand_elem(3) : rand_elem(mode);
      // occasionally force a singular matrix by copying a row
      if ($urandom_range(0, 19) == 0)
        for (int c = 0; c < 3; c++) m.a[6 + c] = m.a[c];
      pending_q.push_back(m);
    end
    stim_done = 1'b1;
  end

  // Reset, then end of run
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb NOT OK");
    $finish;
  end

  // Driver: pops pending matrices, random gaps between transfers
  int gap = 0;
  int sent = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_q.push_back(invert(pending_q.pop_front()));
        sent <= sent + 1;
      end
      if (in_valid && !in_ready) begin
        // hold payload
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_valid <= 1'b1;
        for (int k = 0; k < 9; k++) in_a[k] <= pending_q[0].a[k];
        gap <= ($urandom_range(0, 2) == 0) ?
               (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3)) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares results and drives out_ready
  always @(posedge clk) begin
    inverse_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (out_b[k] !== e.b[k]) begin
              $error("b%0d%0d expected %0d got %0d", k / 3, k % 3, e.b[k], out_b[k]);
              errors++;
            end
          if (out_singular !== e.flags.singular) begin
            $error("singular expected %0b got %0b", e.flags.singular, out_singular);
            errors++;
          end
          if (out_clipped !== e.flags.clipped) begin
            $error("clipped expected %0b got %0b", e.flags.clipped, out_clipped);
            errors++;
          end
        end
      end
      // long hold-off once mid-run so the pipeline backs up
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else if (!long_hold_done && sent >= 300 && in_valid) begin
        hold_cycles <= 10 * LATENCY;
        long_hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        if ($urandom_range(0, 15) == 0) hold_cycles <= $urandom_range(5, 50);
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0) || (sent > 600 && sent < 700);
      end
    end
  end

endmodule

// ===== filelist.f =====
sv/mi3_pkg.sv
sv/mi3_front.sv
sv/mi3_divider.sv
sv/mi3_skid.sv
sv/matrix_inverse_3x3.sv
sim/tb.sv
